// ===== rtl/core/fmc_pkg.sv =====
// Shared types, constants and helpers for the fan mode controller.
// No dependencies; used by fan_mode_controller_unit.
`default_nettype none

package fmc_pkg;

   // item kinds
   localparam logic FUNC_KEY_SCAN = 1'b0;
   localparam logic FUNC_TEMP     = 1'b1;

   // register indexes
   localparam int CSR_IDX_W = 2;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_MIN = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THRESHOLD_MAX = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PRESS_SCANS   = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_BOTH_SCANS    = 2'd3;
   localparam int CSR_DATA_W = 8;

   // register reset values
   localparam logic [6:0] THRESHOLD_MIN_RST = 7'd16;
   localparam logic [6:0] THRESHOLD_MAX_RST = 7'd36;
   localparam logic [7:0] PRESS_SCANS_RST   = 8'd5;
   localparam logic [7:0] BOTH_SCANS_RST    = 8'd10;
   localparam logic [6:0] THRESHOLD_RST     = 7'd26;

   localparam logic [6:0] SEG_BLANK = 7'h00;

   typedef logic [6:0] seg_type;

   typedef struct packed {
      logic    fan_on;
      logic    auto_sel;
      logic    led_green_on;
      logic    led_red_on;
      logic    led_blue_on;
      seg_type seg_first;
      seg_type seg_second;
      seg_type seg_third;
      seg_type seg_fourth;
      logic [6:0] threshold_now;
      logic [7:0] temp_now;
   } rsp_type;

   typedef struct packed {
      logic       func;
      logic       key_up_level;
      logic       key_down_level;
      logic       sensor_present;
      logic [15:0] temp_raw;
   } req_type;

   typedef struct packed {
      logic [4:0] tens;
      logic [3:0] units;
   } digits_type;

   // segment code for one decimal digit, blank above nine
   function automatic seg_type seg_code(input logic [4:0] d);
      seg_type s;
      case (d)
         5'd0:    s = 7'h3F;
         5'd1:    s = 7'h06;
         5'd2:    s = 7'h5B;
         5'd3:    s = 7'h4F;
         5'd4:    s = 7'h66;
         5'd5:    s = 7'h6D;
         5'd6:    s = 7'h7D;
         5'd7:    s = 7'h07;
         5'd8:    s = 7'h7F;
         5'd9:    s = 7'h6F;
         default: s = SEG_BLANK;
      endcase
      return s;
   endfunction

   // split a byte into tens and units: x*205 >> 11 is exact for x below 1029
   function automatic digits_type split_dec(input logic [7:0] v);
      logic [15:0] prod;
      logic [7:0]  tens_x10;
      digits_type  r;
      prod     = {8'd0, v} * 16'd205;
      r.tens   = prod[15:11];
      tens_x10 = {3'd0, r.tens} * 8'd10;
      r.units  = 4'(v - tens_x10);
      return r;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fan_mode_controller_unit.sv =====
// Fan mode controller: key debounce and auto-repeat, mode toggle, auto fan
// switching and seven-segment display codes. Depends on fmc_pkg.
//
// Path: an accepted beat is held in the request register, then moves into
// the result register, or the skid register when the result stalls.
// Throughput: one item per cycle while the result channel does not stall;
// a single compute stage updates state between request and result/skid.
// Reset: synchronous, sets controller state and registers to reset values.
`default_nettype none

module fan_mode_controller_unit (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request channel
   input  wire logic                          req_valid,
   output      logic                          req_stall,
   input  wire logic                          req_func,
   input  wire logic                          req_key_up_level,
   input  wire logic                          req_key_down_level,
   input  wire logic                          req_sensor_present,
   input  wire logic [15:0]                   req_temp_raw,
   // result channel
   output      logic                          rsp_valid,
   input  wire logic                          rsp_stall,
   output      logic                          rsp_fan_on,
   output      logic                          rsp_auto_sel,
   output      logic                          rsp_led_green_on,
   output      logic                          rsp_led_red_on,
   output      logic                          rsp_led_blue_on,
   output      logic [6:0]                    rsp_seg_first,
   output      logic [6:0]                    rsp_seg_second,
   output      logic [6:0]                    rsp_seg_third,
   output      logic [6:0]                    rsp_seg_fourth,
   output      logic [6:0]                    rsp_threshold_now,
   output      logic [7:0]                    rsp_temp_now,
   // configuration
   input  wire logic                          csr_we,
   input  wire logic [fmc_pkg::CSR_IDX_W-1:0] csr_index,
   input  wire logic [fmc_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // configuration registers
   logic [6:0] thr_min_ff, thr_max_ff;
   logic [7:0] press_scans_ff, both_scans_ff;

   // controller state
   logic       mode_auto_ff, mode_auto_in;
   logic       fan_running_ff, fan_running_in;
   logic [6:0] threshold_ff, threshold_in;
   logic [7:0] cur_temp_ff, cur_temp_in;
   logic       up_prev_ff, up_prev_in;
   logic       down_prev_ff, down_prev_in;
   logic [7:0] up_cnt_ff, up_cnt_in;
   logic [7:0] down_cnt_ff, down_cnt_in;
   logic [7:0] both_cnt_ff, both_cnt_in;
   logic       both_latched_ff, both_latched_in;

   // pipeline
   fmc_pkg::req_type req_ff;
   logic             req_valid_ff;
   fmc_pkg::rsp_type rsp_ff, skid_ff, rsp_calc;
   logic             rsp_valid_ff, skid_valid_ff;

   logic accept, fire, take;

   assign req_stall = req_valid_ff & skid_valid_ff;
   assign accept    = req_valid & ~req_stall;
   assign fire      = req_valid_ff & ~skid_valid_ff;
   assign take      = rsp_valid_ff & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_min_ff     <= fmc_pkg::THRESHOLD_MIN_RST;
         thr_max_ff     <= fmc_pkg::THRESHOLD_MAX_RST;
         press_scans_ff <= fmc_pkg::PRESS_SCANS_RST;
         both_scans_ff  <= fmc_pkg::BOTH_SCANS_RST;
      end else if (csr_we) begin
         case (csr_index)
            fmc_pkg::CSR_THRESHOLD_MIN: thr_min_ff     <= csr_wdata[6:0];
            fmc_pkg::CSR_THRESHOLD_MAX: thr_max_ff     <= csr_wdata[6:0];
            fmc_pkg::CSR_PRESS_SCANS:   press_scans_ff <= csr_wdata;
            fmc_pkg::CSR_BOTH_SCANS:    both_scans_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // next state and result for the beat in the request register
   always_comb begin
      logic                upc, dnc, bc;
      fmc_pkg::digits_type td, hd;
      mode_auto_in    = mode_auto_ff;
      fan_running_in  = fan_running_ff;
      threshold_in    = threshold_ff;
      cur_temp_in     = cur_temp_ff;
      up_prev_in      = up_prev_ff;
      down_prev_in    = down_prev_ff;
      up_cnt_in       = up_cnt_ff;
      down_cnt_in     = down_cnt_ff;
      both_cnt_in     = both_cnt_ff;
      both_latched_in = both_latched_ff;
      upc = 1'b0;
      dnc = 1'b0;
      bc  = 1'b0;

      if (req_ff.func == fmc_pkg::FUNC_KEY_SCAN) begin
         // up key: press edge clears, held key counts and repeats
         if (!req_ff.key_up_level) begin
            if (up_prev_ff) begin
               up_cnt_in = '0;
            end else begin
               up_cnt_in = up_cnt_ff + 8'd1;
               if (up_cnt_in >= press_scans_ff) begin
                  up_cnt_in = press_scans_ff - 8'd1;
                  upc = 1'b1;
               end
            end
         end
         if (upc) begin
            if (!mode_auto_ff) begin
               fan_running_in = 1'b1;
            end else if (threshold_in < thr_max_ff) begin
               threshold_in = threshold_in + 7'd1;
            end
         end
         if (!req_ff.key_down_level) begin
            if (down_prev_ff) begin
               down_cnt_in = '0;
            end else begin
               down_cnt_in = down_cnt_ff + 8'd1;
               if (down_cnt_in >= press_scans_ff) begin
                  down_cnt_in = press_scans_ff - 8'd1;
                  dnc = 1'b1;
               end
            end
         end
         if (dnc) begin
            if (!mode_auto_ff) begin
               fan_running_in = 1'b0;
            end else if (threshold_in > thr_min_ff) begin
               threshold_in = threshold_in - 7'd1;
            end
         end
         // both keys held: toggle once per hold, release clears the latch
         if (!req_ff.key_up_level && !req_ff.key_down_level) begin
            if (!both_latched_ff) begin
               both_cnt_in = both_cnt_ff + 8'd1;
               bc = (both_cnt_in >= both_scans_ff);
               if (bc) begin
                  mode_auto_in    = ~mode_auto_ff;
                  both_latched_in = 1'b1;
                  both_cnt_in     = '0;
                  if (mode_auto_ff) fan_running_in = 1'b0;
               end
            end
         end else begin
            both_latched_in = 1'b0;
            both_cnt_in     = '0;
         end
         up_prev_in   = req_ff.key_up_level;
         down_prev_in = req_ff.key_down_level;
      end else begin
         cur_temp_in = req_ff.sensor_present ? req_ff.temp_raw[11:4] : 8'd0;
         if (mode_auto_ff) fan_running_in = (cur_temp_in > {1'b0, threshold_ff});
      end

      td = fmc_pkg::split_dec(cur_temp_in);
      hd = fmc_pkg::split_dec({1'b0, threshold_in});
      rsp_calc.fan_on        = fan_running_in;
      rsp_calc.auto_sel      = mode_auto_in;
      rsp_calc.led_green_on  = ~mode_auto_in & fan_running_in;
      rsp_calc.led_red_on    = ~mode_auto_in & ~fan_running_in;
      rsp_calc.led_blue_on   = mode_auto_in;
      rsp_calc.seg_first     = fmc_pkg::seg_code(td.tens);
      rsp_calc.seg_second    = fmc_pkg::seg_code({1'b0, td.units});
      if (mode_auto_in) begin
         rsp_calc.seg_third  = fmc_pkg::seg_code(hd.tens);
         rsp_calc.seg_fourth = fmc_pkg::seg_code({1'b0, hd.units});
      end else begin
         rsp_calc.seg_third  = fmc_pkg::seg_code(5'd0);
         rsp_calc.seg_fourth = fmc_pkg::seg_code({4'd0, fan_running_in});
      end
      rsp_calc.threshold_now = threshold_in;
      rsp_calc.temp_now      = cur_temp_in;
   end

   // state advances only when a beat leaves the request register
   always_ff @(posedge clock) begin
      if (reset) begin
         mode_auto_ff    <= 1'b0;
         fan_running_ff  <= 1'b0;
         threshold_ff    <= fmc_pkg::THRESHOLD_RST;
         cur_temp_ff     <= '0;
         up_prev_ff      <= 1'b1;
         down_prev_ff    <= 1'b1;
         up_cnt_ff       <= '0;
         down_cnt_ff     <= '0;
         both_cnt_ff     <= '0;
         both_latched_ff <= 1'b0;
      end else if (fire) begin
         mode_auto_ff    <= mode_auto_in;
         fan_running_ff  <= fan_running_in;
         threshold_ff    <= threshold_in;
         cur_temp_ff     <= cur_temp_in;
         up_prev_ff      <= up_prev_in;
         down_prev_ff    <= down_prev_in;
         up_cnt_ff       <= up_cnt_in;
         down_cnt_ff     <= down_cnt_in;
         both_cnt_ff     <= both_cnt_in;
         both_latched_ff <= both_latched_in;
      end
   end

   // request register
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else if (accept) begin
         req_valid_ff <= 1'b1;
      end else if (fire) begin
         req_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         req_ff.func           <= req_func;
         req_ff.key_up_level   <= req_key_up_level;
         req_ff.key_down_level <= req_key_down_level;
         req_ff.sensor_present <= req_sensor_present;
         req_ff.temp_raw       <= req_temp_raw;
      end
   end

   // result register with skid: hold the result while stalled, park the next
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (!rsp_valid_ff || take) begin
         rsp_valid_ff  <= skid_valid_ff | fire;
         skid_valid_ff <= 1'b0;
      end else if (fire) begin
         skid_valid_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (!rsp_valid_ff || take) begin
         rsp_ff <= skid_valid_ff ? skid_ff : rsp_calc;
      end else if (fire) begin
         skid_ff <= rsp_calc;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fan_on        = rsp_ff.fan_on;
   assign rsp_auto_sel      = rsp_ff.auto_sel;
   assign rsp_led_green_on  = rsp_ff.led_green_on;
   assign rsp_led_red_on    = rsp_ff.led_red_on;
   assign rsp_led_blue_on   = rsp_ff.led_blue_on;
   assign rsp_seg_first     = rsp_ff.seg_first;
   assign rsp_seg_second    = rsp_ff.seg_second;
   assign rsp_seg_third     = rsp_ff.seg_third;
   assign rsp_seg_fourth    = rsp_ff.seg_fourth;
   assign rsp_threshold_now = rsp_ff.threshold_now;
   assign rsp_temp_now      = rsp_ff.temp_now;

endmodule

`default_nettype wire
